@@ src/gup_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gup_pkg;

   localparam int CHUNK_DEF     = 100;
   localparam int BUF_WORDS_DEF = 32;
   localparam int MAX_RESULTS   = 32;

   localparam int WORD_CNT_W = 6;
   localparam int CODE_W     = 9;

   localparam logic [CODE_W-1:0] CODE_CLEAR = 9'h100;
   localparam logic [CODE_W-1:0] CODE_END   = 9'h101;

   localparam logic [1:0] KIND_LEN  = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_TERM = 2'd2;

   // Block command from the packer to the emitter
   typedef struct packed {
      logic                  bank;
      logic [WORD_CNT_W-1:0] words;
      logic [2:0]            part_bytes;
      logic [31:0]           part_word;
      logic                  has_block;
      logic                  term;
   } gup_cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } gup_done_type;

   // Quantize one 8-bit channel to a level 0..5 of the color cube
   function automatic logic [2:0] cube_level(input logic [7:0] v);
      logic [2:0] q;
      if (v >= 8'd235) begin
         q = 3'd5;
      end else if (v >= 8'd188) begin
         q = 3'd4;
      end else if (v >= 8'd141) begin
         q = 3'd3;
      end else if (v >= 8'd94) begin
         q = 3'd2;
      end else if (v >= 8'd47) begin
         q = 3'd1;
      end else begin
         q = 3'd0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

@@ src/gup_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gup_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/gup_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gup_cmd_fifo
   import gup_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire gup_cmd_type in_cmd,
   output logic             out_valid,
   input  wire logic        out_ready,
   output gup_cmd_type      out_cmd
);

   gup_cmd_type ent_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = ent_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= in_cmd;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/gup_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gup_front
   import gup_pkg::*;
#(
   parameter int CHUNK     = CHUNK_DEF,
   parameter int BUF_WORDS = BUF_WORDS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           px_valid,
   output logic                                px_ready,
   input  wire logic [7:0]                     red,
   input  wire logic [7:0]                     green,
   input  wire logic [7:0]                     blue,
   input  wire logic                           frame_end,
   output logic                                wr_en,
   output logic [$clog2(BUF_WORDS):0]          wr_addr,
   output logic [31:0]                         wr_data,
   output logic                                cmd_valid,
   input  wire logic                           cmd_ready,
   output gup_cmd_type                         cmd,
   input  wire gup_done_type                   done
);

   localparam int IDX_W    = $clog2(BUF_WORDS);
   localparam int CHUNK_W  = $clog2(CHUNK + 1);
   localparam int WORD_CAP = (BUF_WORDS < MAX_RESULTS - 3) ? BUF_WORDS : MAX_RESULTS - 3;

   logic [31:0]           acc_ff, acc_in;
   logic [4:0]            held_ff, held_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [WORD_CNT_W-1:0] wcnt_ff, wcnt_in;
   logic                  bank_ff, bank_in;
   logic [1:0]            busy_ff, busy_in;

   logic                  accept;
   logic [7:0]            index;
   logic                  first;
   logic [26:0]           codes;
   logic [5:0]            nbits;
   logic [58:0]           packed_bits;
   logic [5:0]            total;
   logic                  full_word;
   logic                  store;
   logic [WORD_CNT_W-1:0] wcnt_new;
   logic [4:0]            held_new;
   logic [31:0]           acc_new;
   logic [5:0]            part_sum;
   logic [2:0]            part;
   logic [CHUNK_W-1:0]    chunk_next;
   logic                  chunk_end;

   assign px_ready = cmd_ready && !busy_ff[bank_ff];
   assign accept   = px_valid && px_ready;

   assign index = 8'(cube_level(red)) * 8'd36 + 8'(cube_level(green)) * 8'd6
                  + 8'(cube_level(blue));
   assign first = (chunk_ff == '0);

   // Gather this pixel's codes in stream order, lowest bits first
   always_comb begin
      priority if (first && frame_end) begin
         codes = {CODE_END, 1'b0, index, CODE_CLEAR};
         nbits = 6'd27;
      end else if (first) begin
         codes = {9'd0, 1'b0, index, CODE_CLEAR};
         nbits = 6'd18;
      end else if (frame_end) begin
         codes = {9'd0, CODE_END, 1'b0, index};
         nbits = 6'd18;
      end else begin
         codes = {18'd0, 1'b0, index};
         nbits = 6'd9;
      end
   end

   assign packed_bits = {27'd0, acc_ff} | ({32'd0, codes} << held_ff);
   assign total       = {1'b0, held_ff} + nbits;
   assign full_word   = (total >= 6'd32);
   assign store       = full_word && (wcnt_ff < WORD_CNT_W'(WORD_CAP));
   assign wcnt_new    = wcnt_ff + WORD_CNT_W'(store);
   assign held_new    = full_word ? 5'(total - 6'd32) : total[4:0];
   assign acc_new     = full_word ? {5'd0, packed_bits[58:32]} : packed_bits[31:0];
   assign part_sum    = {1'b0, held_new} + 6'd7;
   assign part        = part_sum[5:3];
   assign chunk_next  = chunk_ff + CHUNK_W'(1);
   assign chunk_end   = (chunk_next >= CHUNK_W'(CHUNK));

   assign wr_en   = accept && store;
   assign wr_addr = {bank_ff, IDX_W'(wcnt_ff)};
   assign wr_data = packed_bits[31:0];

   assign cmd_valid = accept && (frame_end || (chunk_end && wcnt_new != '0));
   always_comb begin
      cmd.bank       = bank_ff;
      cmd.words      = wcnt_new;
      cmd.part_bytes = frame_end ? part : 3'd0;
      cmd.part_word  = acc_new;
      cmd.has_block  = (wcnt_new != '0) || (frame_end && part != 3'd0);
      cmd.term       = frame_end;
   end

   always_comb begin
      acc_in   = acc_ff;
      held_in  = held_ff;
      chunk_in = chunk_ff;
      wcnt_in  = wcnt_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (done.valid) busy_in[done.bank] = 1'b0;
      if (accept) begin
         acc_in   = acc_new;
         held_in  = held_new;
         chunk_in = chunk_next;
         wcnt_in  = wcnt_new;
         if (cmd_valid) begin
            busy_in[bank_ff] = 1'b1;
            bank_in          = ~bank_ff;
         end
         if (frame_end) begin
            acc_in   = '0;
            held_in  = '0;
            chunk_in = '0;
            wcnt_in  = '0;
         end else if (chunk_end) begin
            chunk_in = '0;
            wcnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         held_ff  <= '0;
         chunk_ff <= '0;
         wcnt_ff  <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         acc_ff   <= acc_in;
         held_ff  <= held_in;
         chunk_ff <= chunk_in;
         wcnt_ff  <= wcnt_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

`default_nettype wire

@@ src/gup_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gup_emitter
   import gup_pkg::*;
#(
   parameter int BUF_WORDS = BUF_WORDS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   output logic                          cmd_ready,
   input  wire gup_cmd_type              cmd,
   output logic [$clog2(BUF_WORDS):0]    rd_addr,
   input  wire logic [31:0]              rd_data,
   output gup_done_type                  done,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [1:0]                    out_kind,
   output logic [31:0]                   out_word,
   output logic [2:0]                    out_bytes,
   output logic                          out_last
);

   localparam int IDX_W = $clog2(BUF_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_RD,
      ST_WORD,
      ST_PART,
      ST_TERM
   } state_type;

   state_type             state_ff;
   gup_cmd_type           cmd_ff;
   logic [WORD_CNT_W-1:0] widx_ff;
   logic                  out_valid_ff;
   logic [1:0]            kind_ff;
   logic [31:0]           word_ff;
   logic [2:0]            bytes_ff;
   logic                  last_ff;
   gup_done_type          done_ff;

   logic                  slot_free;
   logic                  final_word;
   logic [7:0]            len_byte;
   logic                  fire;
   logic                  finish;

   assign slot_free  = !out_valid_ff || out_ready;
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign rd_addr    = {cmd_ff.bank, IDX_W'(widx_ff)};
   assign final_word = (widx_ff == cmd_ff.words - WORD_CNT_W'(1));
   assign len_byte   = {cmd_ff.words, 2'b00} + {5'd0, cmd_ff.part_bytes};

   assign fire   = slot_free && (state_ff != ST_IDLE) && (state_ff != ST_RD);
   // release the bank with the last transaction of the command
   assign finish = fire && ((state_ff == ST_TERM) || (!cmd_ff.term &&
                   ((state_ff == ST_PART) ||
                    (state_ff == ST_WORD && final_word && cmd_ff.part_bytes == 3'd0))));

   assign out_valid = out_valid_ff;
   assign out_kind  = kind_ff;
   assign out_word  = word_ff;
   assign out_bytes = bytes_ff;
   assign out_last  = last_ff;
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         done_ff       <= '0;
         widx_ff       <= '0;
      end else begin
         out_valid_ff <= fire || (out_valid_ff && !out_ready);
         done_ff      <= '{valid: finish, bank: cmd_ff.bank};
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  widx_ff  <= '0;
                  state_ff <= cmd.has_block ? ST_LEN : ST_TERM;
               end
            end
            ST_LEN: begin
               if (slot_free) begin
                  kind_ff      <= KIND_LEN;
                  word_ff      <= {24'd0, len_byte};
                  bytes_ff     <= 3'd1;
                  last_ff      <= 1'b0;
                  priority if (cmd_ff.words != '0) begin
                     state_ff <= ST_RD;
                  end else if (cmd_ff.part_bytes != 3'd0) begin
                     state_ff <= ST_PART;
                  end else begin
                     state_ff <= ST_TERM;
                  end
               end
            end
            ST_RD: begin
               // let the store's registered read settle
               state_ff <= ST_WORD;
            end
            ST_WORD: begin
               if (slot_free) begin
                  kind_ff      <= KIND_WORD;
                  word_ff      <= rd_data;
                  bytes_ff     <= 3'd4;
                  last_ff      <= final_word && cmd_ff.part_bytes == 3'd0 && !cmd_ff.term;
                  widx_ff      <= widx_ff + WORD_CNT_W'(1);
                  priority if (!final_word) begin
                     state_ff <= ST_RD;
                  end else if (cmd_ff.part_bytes != 3'd0) begin
                     state_ff <= ST_PART;
                  end else if (cmd_ff.term) begin
                     state_ff <= ST_TERM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_PART: begin
               if (slot_free) begin
                  kind_ff      <= KIND_WORD;
                  word_ff      <= cmd_ff.part_word;
                  bytes_ff     <= cmd_ff.part_bytes;
                  last_ff      <= !cmd_ff.term;
                  if (cmd_ff.term) begin
                     state_ff <= ST_TERM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_TERM: begin
               if (slot_free) begin
                  kind_ff      <= KIND_TERM;
                  word_ff      <= '0;
                  bytes_ff     <= 3'd1;
                  last_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ src/gif_uncompressed_pixel_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Uncompressed GIF image-data packer. Each RGB pixel maps to an index of the
// 216-entry color cube and goes out as a 9-bit code, least significant bit
// first, with a clear code opening every CHUNK pixels and the end code plus
// byte padding after the pixel marked by req_tlast. Each chunk leaves as one
// sub-block: a length byte, full 32-bit words, then on image end a partial
// word and a zero terminator byte. The packer writes words into one half of
// a double-banked word store and hands a block command through a two-entry
// queue to the emitter, which drains the other half with a read state and a
// word state per stored word and one state per length, partial or terminator
// transaction. The packer stalls when the bank it is filling is still
// draining or the command queue is full, so with chunks of 100 pixels it
// sustains one pixel per cycle when the result side keeps up.
module gif_uncompressed_pixel_packer
   import gup_pkg::*;
#(
   parameter int CHUNK     = CHUNK_DEF,
   parameter int BUF_WORDS = BUF_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  wire logic        req_tlast,   // frame_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // data_word[31:0], valid_bytes[34:32], zero
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // run_last
);

   localparam int ADDR_W = $clog2(BUF_WORDS) + 1;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [31:0]        rd_data;
   logic               fq_valid, fq_ready;
   gup_cmd_type        fq_cmd;
   logic               bq_valid, bq_ready;
   gup_cmd_type        bq_cmd;
   gup_done_type       done;
   logic [31:0]        out_word;
   logic [2:0]         out_bytes;

   gup_front #(
      .CHUNK     (CHUNK),
      .BUF_WORDS (BUF_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .px_valid  (req_tvalid),
      .px_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .frame_end (req_tlast),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd),
      .done      (done)
   );

   gup_ram #(
      .WIDTH (32),
      .DEPTH (2 ** ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gup_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_cmd   (bq_cmd)
   );

   gup_emitter #(
      .BUF_WORDS (BUF_WORDS)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bq_valid),
      .cmd_ready (bq_ready),
      .cmd       (bq_cmd),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .done      (done),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_word  (out_word),
      .out_bytes (out_bytes),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, out_bytes, out_word};

endmodule

`default_nettype wire
